[hdl/sll_pkg.sv]
package sll_pkg;

   // Operation codes carried in req_tuser.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2
   } cmd_type;

   // Status codes carried in rsp_tuser.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_UPD1,
      S_UPD2,
      S_RESP
   } state_type;

   // Width of the value field.
   localparam int unsigned VALUE_W = 32;

   // Width of the slot and count result fields.
   localparam int unsigned FIELD_W = 6;

endpackage

[hdl/sorted_linked_list_engine.sv]
// Channel  Direction  Signals                  Contents (lowest bit first)
// req      in         tvalid tready tdata tuser tdata: value[31:0]; tuser: command[1:0]
// rsp      out        tvalid tready tdata tuser tdata: slot[5:0] count[11:6], zero fill
//                                               to 16 bits; tuser: status[1:0]
//
// A delete, a search or an insert with a free slot walks the list from the anchor;
// the walk visits one node per cycle through the registered read port of the link
// and value memories. After reset a clearing pass builds the free chain in the link
// memory; no transaction is accepted on req until it ends.
// A new request is taken while a finished result still waits on rsp.
module sorted_linked_list_engine #(
   parameter int unsigned POOL_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // slot[5:0], count[11:6], zeros[15:12]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int unsigned SLOT_W = (POOL_SLOTS > 2) ? $clog2(POOL_SLOTS) : 1;
   localparam int unsigned EXT_W  = (SLOT_W > sll_pkg::FIELD_W) ? SLOT_W : sll_pkg::FIELD_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

   // Link and value memories.
   logic [SLOT_W-1:0]           link_mem [POOL_SLOTS];
   logic [sll_pkg::VALUE_W-1:0] val_mem  [POOL_SLOTS];

   logic                        link_we;
   logic [SLOT_W-1:0]           link_wa;
   logic [SLOT_W-1:0]           link_wd;
   logic                        val_we;
   logic [SLOT_W-1:0]           val_wa;
   logic [SLOT_W-1:0]           rd_addr;
   logic [SLOT_W-1:0]           link_rd_ff;
   logic [sll_pkg::VALUE_W-1:0] val_rd_ff;

   // Control and working registers.
   sll_pkg::state_type          state_ff, state_in;
   logic [SLOT_W-1:0]           clr_ff, clr_in;
   sll_pkg::cmd_type            cmd_ff;
   logic [sll_pkg::VALUE_W-1:0] val_ff;
   logic [SLOT_W-1:0]           cur_ff, cur_in;
   logic [SLOT_W-1:0]           prev_ff, prev_in;
   logic [SLOT_W-1:0]           node_ff, node_in;
   logic [SLOT_W-1:0]           nxt_ff, nxt_in;
   logic [SLOT_W-1:0]           free_ff, free_in;
   logic [SLOT_W-1:0]           count_ff, count_in;
   sll_pkg::status_type         res_status_ff, res_status_in;
   logic [SLOT_W-1:0]           res_slot_ff, res_slot_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   sll_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [sll_pkg::FIELD_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [sll_pkg::FIELD_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        req_accept;
   logic                        node_hit;
   logic [EXT_W-1:0]            slot_ext;
   logic [EXT_W-1:0]            count_ext;

   assign req_tready = (state_ff == sll_pkg::S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_slot_ff};

   // A node matches when it is a real node (not the anchor) and its value
   // is not below the key for an insert, or equal to the key otherwise.
   always_comb begin
      if (cmd_ff == sll_pkg::CMD_INSERT) begin
         node_hit = (cur_ff != '0) && ($signed(val_rd_ff) >= $signed(val_ff));
      end else begin
         node_hit = (cur_ff != '0) && (val_rd_ff == val_ff);
      end
   end

   // Memory writes.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (val_we) begin
         val_mem[val_wa] <= val_ff;
      end
   end

   // Memory reads, registered.
   always_ff @(posedge clock) begin
      link_rd_ff <= link_mem[rd_addr];
      val_rd_ff  <= val_mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sll_pkg::S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= SLOT_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= sll_pkg::cmd_type'(req_tuser);
         val_ff <= req_tdata;
      end
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      node_ff       <= node_in;
      nxt_ff        <= nxt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Result fields are masked to the width of the result port.
   assign slot_ext  = EXT_W'(res_slot_ff);
   assign count_ext = EXT_W'(count_ff);

   // Sequencer: clearing pass, list walk and read-modify-write of the links.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      node_in       = node_ff;
      nxt_in        = nxt_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      link_we       = 1'b0;
      link_wa       = '0;
      link_wd       = '0;
      val_we        = 1'b0;
      val_wa        = '0;
      rd_addr       = '0;

      case (state_ff)
         sll_pkg::S_CLEAR: begin
            // Each slot links to the next; the anchor and the last slot end.
            link_we = 1'b1;
            link_wa = clr_ff;
            if ((clr_ff == '0) || (clr_ff == LAST_SLOT)) begin
               link_wd = '0;
            end else begin
               link_wd = clr_ff + SLOT_W'(1);
            end
            clr_in = clr_ff + SLOT_W'(1);
            if (clr_ff == LAST_SLOT) begin
               clr_in   = '0;
               state_in = sll_pkg::S_IDLE;
            end
         end

         sll_pkg::S_IDLE: begin
            cur_in  = '0;
            prev_in = '0;
            if (req_accept) begin
               case (req_tuser)
                  sll_pkg::CMD_INSERT: begin
                     if (free_ff == '0) begin
                        res_status_in = sll_pkg::ST_FULL;
                        res_slot_in   = '0;
                        state_in      = sll_pkg::S_RESP;
                     end else begin
                        state_in = sll_pkg::S_WALK;
                     end
                  end
                  sll_pkg::CMD_DELETE,
                  sll_pkg::CMD_SEARCH: begin
                     state_in = sll_pkg::S_WALK;
                  end
                  default: begin
                     res_status_in = sll_pkg::ST_OK;
                     res_slot_in   = '0;
                     state_in      = sll_pkg::S_RESP;
                  end
               endcase
            end
         end

         sll_pkg::S_WALK: begin
            // The read data belongs to cur_ff; the anchor never matches.
            if (node_hit) begin
               node_in = cur_ff;
               nxt_in  = link_rd_ff;
               if (cmd_ff == sll_pkg::CMD_SEARCH) begin
                  res_status_in = sll_pkg::ST_OK;
                  res_slot_in   = cur_ff;
                  state_in      = sll_pkg::S_RESP;
               end else begin
                  state_in = sll_pkg::S_UPD1;
               end
            end else if (link_rd_ff == '0) begin
               node_in = '0;
               prev_in = cur_ff;
               if (cmd_ff == sll_pkg::CMD_INSERT) begin
                  state_in = sll_pkg::S_UPD1;
               end else begin
                  res_status_in = sll_pkg::ST_MISSING;
                  res_slot_in   = '0;
                  state_in      = sll_pkg::S_RESP;
               end
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rd_ff;
               rd_addr = link_rd_ff;
            end
         end

         sll_pkg::S_UPD1: begin
            link_we = 1'b1;
            link_wa = prev_ff;
            if (cmd_ff == sll_pkg::CMD_INSERT) begin
               // Link the free head after the predecessor, store the value,
               // and fetch the link of the free head.
               link_wd = free_ff;
               val_we  = 1'b1;
               val_wa  = free_ff;
               rd_addr = free_ff;
            end else begin
               // Bypass the deleted node.
               link_wd = nxt_ff;
            end
            state_in = sll_pkg::S_UPD2;
         end

         sll_pkg::S_UPD2: begin
            link_we       = 1'b1;
            res_status_in = sll_pkg::ST_OK;
            if (cmd_ff == sll_pkg::CMD_INSERT) begin
               link_wa     = free_ff;
               link_wd     = node_ff;
               free_in     = link_rd_ff;
               count_in    = count_ff + SLOT_W'(1);
               res_slot_in = free_ff;
            end else begin
               // Push the deleted node onto the free chain.
               link_wa     = node_ff;
               link_wd     = free_ff;
               free_in     = node_ff;
               if (count_ff != '0) begin
                  count_in = count_ff - SLOT_W'(1);
               end
               res_slot_in = node_ff;
            end
            state_in = sll_pkg::S_RESP;
         end

         sll_pkg::S_RESP: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot_ext[sll_pkg::FIELD_W-1:0];
               rsp_count_in  = count_ext[sll_pkg::FIELD_W-1:0];
               state_in      = sll_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sll_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[test/sorted_linked_list_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the sorted list engine, predicts every reply
// from its own copy of the node pool and compares replies in order.
module sorted_linked_list_checker #(
   parameter int unsigned POOL_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [1:0]  req_tuser,   // command[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // slot[5:0], count[11:6], zeros[15:12]
   input  logic [1:0]  rsp_tuser,   // status[1:0]
   output int          mismatch_count,
   output int          replies_pending
);

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      sll_pkg::status_type         status;
      logic [sll_pkg::FIELD_W-1:0] slot;
      logic [sll_pkg::FIELD_W-1:0] count;
   } list_reply_type;

   // Shadow copy of the node pool, the free chain and the list length.
   int unsigned                        next_slot [POOL_SLOTS];
   logic signed [sll_pkg::VALUE_W-1:0] node_value [POOL_SLOTS];
   int unsigned                        free_slot;
   int unsigned                        list_size;
   list_reply_type                     reply_queue [$];

   // Rebuild the pool as it stands after reset: every slot but the anchor
   // sits on the free chain in ascending order.
   function automatic void clear_pool();
      for (int unsigned i = 0; i < POOL_SLOTS; i++) begin
         next_slot[i] = (i == 0 || i == POOL_SLOTS - 1) ? 0 : i + 1;
         node_value[i] = '0;
      end
      free_slot = 1;
      list_size = 0;
   endfunction

   // Walk from the anchor. With exact set, stop at the first node equal to
   // the key, otherwise at the first node not below it. Returns 0 when the
   // walk runs off the end; pred names the node in front of the stop.
   function automatic int unsigned find_node(
         input logic signed [sll_pkg::VALUE_W-1:0] key,
         input bit exact,
         output int unsigned pred);
      int unsigned prev;
      int unsigned cur;
      int unsigned steps;
      prev = 0;
      cur = next_slot[0];
      steps = 0;
      while (cur != 0 && cur < POOL_SLOTS && steps < POOL_SLOTS) begin
         if (exact ? (node_value[cur] == key) : (node_value[cur] >= key)) begin
            pred = prev;
            return cur;
         end
         prev = cur;
         cur = next_slot[cur];
         steps++;
      end
      pred = prev;
      return 0;
   endfunction

   // Apply one command to the shadow pool and return the reply it earns.
   function automatic list_reply_type apply_list_command(
         input logic [1:0] op,
         input logic [sll_pkg::VALUE_W-1:0] raw);
      logic signed [sll_pkg::VALUE_W-1:0] key;
      list_reply_type                     reply;
      int unsigned                        fresh;
      int unsigned                        node;
      int unsigned                        pred;
      key = raw;
      reply.status = sll_pkg::ST_OK;
      reply.slot = '0;
      case (op)
         sll_pkg::CMD_INSERT: begin
            fresh = free_slot;
            if (fresh == 0 || fresh >= POOL_SLOTS) begin
               reply.status = sll_pkg::ST_FULL;
            end else begin
               node = find_node(key, 1'b0, pred);
               free_slot = next_slot[fresh];
               next_slot[pred] = fresh;
               next_slot[fresh] = node;
               node_value[fresh] = key;
               list_size++;
               reply.slot = fresh[sll_pkg::FIELD_W-1:0];
            end
         end
         sll_pkg::CMD_DELETE, sll_pkg::CMD_SEARCH: begin
            node = find_node(key, 1'b1, pred);
            if (node == 0) begin
               reply.status = sll_pkg::ST_MISSING;
            end else begin
               reply.slot = node[sll_pkg::FIELD_W-1:0];
               if (op == sll_pkg::CMD_DELETE) begin
                  next_slot[pred] = next_slot[node];
                  next_slot[node] = free_slot;
                  free_slot = node;
                  if (list_size > 0) list_size--;
               end
            end
         end
         default: begin
            // The unused command code leaves the pool untouched.
         end
      endcase
      reply.count = list_size[sll_pkg::FIELD_W-1:0];
      return reply;
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   // Compare each reply transaction with the oldest prediction, then
   // predict the reply for any request transaction on the same edge.
   always @(posedge clock) begin : watch_channels
      list_reply_type want;
      if (reset) begin
         clear_pool();
         reply_queue.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_queue.size() == 0) begin
               report_mismatch($sformatf(
                  "%0t: unexpected reply status=%0d slot=%0d count=%0d",
                  $realtime, rsp_tuser, rsp_tdata[5:0], rsp_tdata[11:6]));
            end else begin
               want = reply_queue.pop_front();
               if (rsp_tuser !== want.status || rsp_tdata[5:0] !== want.slot ||
                   rsp_tdata[11:6] !== want.count || rsp_tdata[15:12] !== 4'b0) begin
                  report_mismatch($sformatf(
                     "%0t: expected status=%0d slot=%0d count=%0d fill=0, got %0d %0d %0d %h",
                     $realtime, want.status, want.slot, want.count, rsp_tuser,
                     rsp_tdata[5:0], rsp_tdata[11:6], rsp_tdata[15:12]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            reply_queue.push_back(apply_list_command(req_tuser, req_tdata));
         end
      end
      replies_pending = reply_queue.size();
   end

endmodule

[test/sorted_linked_list_engine_tb.sv]
`timescale 1ns / 1ps

module sorted_linked_list_engine_tb;

   localparam int unsigned POOL_SLOTS     = 64;
   localparam int unsigned ITEM_TOTAL     = 1350;
   localparam int unsigned PHASE_ITEMS    = 150;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES    = 500;
   localparam int unsigned DRAIN_CYCLES   = 100;
   localparam logic [1:0]  CMD_UNUSED     = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // value[31:0]
   logic [1:0]  req_tuser;    // command[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // slot[5:0], count[11:6], zeros[15:12]
   logic [1:0]  rsp_tuser;    // status[1:0]

   int mismatch_count;
   int replies_pending;
   int replies_taken;
   int quiet_cycles;
   bit hold_done;

   // Values currently in the list, used only to aim keys at list members.
   logic [31:0] live_values [$];

   // Per-phase command mix: fill, drain and mixed.
   int unsigned insert_pct [3] = '{85, 12, 40};
   int unsigned delete_pct [3] = '{90, 75, 70};

   sorted_linked_list_engine #(
      .POOL_SLOTS(POOL_SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   sorted_linked_list_checker #(
      .POOL_SLOTS(POOL_SLOTS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .replies_pending(replies_pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Count reply transactions and end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         replies_taken <= 0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) replies_taken <= replies_taken + 1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Offer one request and hold it until the engine takes it.
   task automatic send_command(input logic [1:0] op, input logic [31:0] key);
      int hit;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= key;
      do @(posedge clock); while (!req_tready);
      hit = -1;
      case (op)
         sll_pkg::CMD_INSERT: begin
            if (live_values.size() < POOL_SLOTS - 1) live_values.push_back(key);
         end
         sll_pkg::CMD_DELETE: begin
            foreach (live_values[i]) if (hit < 0 && live_values[i] == key) hit = i;
            if (hit >= 0) live_values.delete(hit);
         end
         default: begin
         end
      endcase
   endtask

   task automatic idle_sender(input int unsigned cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stop offering requests until every predicted reply has come back.
   task automatic drain_replies();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (replies_pending == 0);
   endtask

   // Values hit the list at the given percentage, else come from a small range that
   // breeds duplicates or are fully random so every bit toggles.
   function automatic logic [31:0] pick_key(input int unsigned hit_pct);
      int unsigned r;
      if (live_values.size() > 0 && $urandom_range(0, 99) < hit_pct)
         return live_values[$urandom_range(0, live_values.size() - 1)];
      if ($urandom_range(0, 3) == 0) begin
         r = $urandom_range(0, 9);
         if (r == 0) return 32'h8000_0000;
         if (r == 1) return 32'h7FFF_FFFF;
         return 32'(int'(r) - 5);
      end
      return $urandom;
   endfunction

   function automatic logic [1:0] pick_command(input int unsigned phase);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < insert_pct[phase]) return sll_pkg::CMD_INSERT;
      if (r < delete_pct[phase]) return sll_pkg::CMD_DELETE;
      if (r < 98) return sll_pkg::CMD_SEARCH;
      return CMD_UNUSED;
   endfunction

   // Reply side: random stalls, one long hold-off, and a stretch always ready.
   initial begin : receiver
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && replies_taken >= 300) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (replies_taken >= 600 && replies_taken < 800) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 11);
         end
      end
   end

   // Request side: directed corner cases, then phased random traffic.
   initial begin : sender
      logic [1:0]  op;
      logic [31:0] key;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = sll_pkg::CMD_INSERT;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty list, unused code, extremes, duplicates and full cleanup.
      send_command(sll_pkg::CMD_SEARCH, 32'h0000_0000);
      send_command(sll_pkg::CMD_DELETE, 32'h0000_0005);
      send_command(CMD_UNUSED, 32'hFFFF_FFFF);
      send_command(sll_pkg::CMD_INSERT, 32'h7FFF_FFFF);
      send_command(sll_pkg::CMD_INSERT, 32'h8000_0000);
      send_command(sll_pkg::CMD_INSERT, 32'h0000_0000);
      send_command(sll_pkg::CMD_INSERT, 32'hFFFF_FFFF);
      send_command(sll_pkg::CMD_INSERT, 32'h0000_0000);
      send_command(sll_pkg::CMD_SEARCH, 32'h0000_0000);
      send_command(sll_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
      send_command(sll_pkg::CMD_SEARCH, 32'h8000_0000);
      send_command(sll_pkg::CMD_SEARCH, 32'h0000_3039);
      send_command(sll_pkg::CMD_DELETE, 32'h0000_0000);
      send_command(sll_pkg::CMD_DELETE, 32'h0000_0000);
      send_command(sll_pkg::CMD_DELETE, 32'h0000_0000);
      send_command(CMD_UNUSED, 32'h0000_0000);
      send_command(sll_pkg::CMD_INSERT, 32'h5555_5555);
      send_command(sll_pkg::CMD_INSERT, 32'hAAAA_AAAA);
      send_command(sll_pkg::CMD_DELETE, 32'h8000_0000);
      send_command(sll_pkg::CMD_DELETE, 32'h7FFF_FFFF);
      send_command(sll_pkg::CMD_DELETE, 32'hFFFF_FFFF);
      send_command(sll_pkg::CMD_DELETE, 32'hAAAA_AAAA);
      send_command(sll_pkg::CMD_DELETE, 32'h5555_5555);
      send_command(sll_pkg::CMD_SEARCH, 32'hFFFF_FFFF);

      // Phases alternate between filling the pool, draining it and a mix.
      for (int unsigned item = 0; item < ITEM_TOTAL; item++) begin
         if (item == 900) begin
            drain_replies();
         end else if ((item < 500 || item >= 700) && $urandom_range(0, 99) < 11) begin
            idle_sender($urandom_range(1, 4));
         end
         op = pick_command((item / PHASE_ITEMS) % 3);
         key = pick_key((op == sll_pkg::CMD_INSERT) ? 10 : 75);
         send_command(op, key);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (replies_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && replies_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
